// ----- rtl/core/hnm_pkg.sv -----
// ----------------------------------------------------------------------------
// hnm_pkg
// Shared constants, codes and types of the hierarchy node mapper.
// ----------------------------------------------------------------------------
package hnm_pkg;

  localparam int NODES_DEF    = 255;
  localparam int KEY_BITS_DEF = 32;
  localparam int KEY_FIELD_W  = 32;
  localparam int PORT_W       = 8;
  localparam int EMPTY_PORT   = 255;

  // operation field codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MAP  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_TGT_FULL   = 2'd1,
    STAT_SRC_FULL   = 2'd2,
    STAT_BAD_PARENT = 2'd3
  } hnm_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_PARENT,
    S_SEARCH,
    S_OUT
  } hnm_state_t;

  // flags of the search token that walks the cell row
  typedef struct packed {
    logic valid;
    logic hit;
  } hnm_tok_t;

endpackage

// ----- rtl/core/hnm_channels_if.sv -----
// ----------------------------------------------------------------------------
// hnm channel interfaces
// Valid/ready channels for items, results and the configuration write.
// ----------------------------------------------------------------------------
interface hnm_in_if;
  import hnm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic                   first;
  logic [KEY_FIELD_W-1:0] node_key;
  logic [PORT_W-1:0]      parent_port;

  modport source (output valid, operation, first, node_key, parent_port, input ready);
  modport sink   (input valid, operation, first, node_key, parent_port, output ready);
endinterface

interface hnm_out_if;
  import hnm_pkg::*;
  logic              valid;
  logic              ready;
  logic [PORT_W-1:0] mapped_port;
  logic              appended;
  logic [1:0]        status;

  modport source (output valid, mapped_port, appended, status, input ready);
  modport sink   (input valid, mapped_port, appended, status, output ready);
endinterface

interface hnm_cfg_if;
  logic valid;
  logic ready;
  logic merge_enable;

  modport source (output valid, merge_enable, input ready);
  modport sink   (input valid, merge_enable, output ready);
endinterface

// ----- rtl/core/hnm_cell.sv -----
// ----------------------------------------------------------------------------
// hnm_cell
// One target table entry plus one stage of the search token row.
// ----------------------------------------------------------------------------
module hnm_cell #(
  parameter int IW  = hnm_pkg::PORT_W,
  parameter int KW  = hnm_pkg::KEY_BITS_DEF,
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IW-1:0]    wr_addr,
  input  logic [KW-1:0]    wr_key,
  input  logic [IW-1:0]    wr_par,
  input  logic [KW-1:0]    srch_key,
  input  logic [IW-1:0]    srch_sp,
  input  logic [IW-1:0]    orig_cnt,
  input  hnm_pkg::hnm_tok_t tok_in,
  input  logic [IW-1:0]    port_in,
  output hnm_pkg::hnm_tok_t tok_out,
  output logic [IW-1:0]    port_out
);
  import hnm_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [KW-1:0] key_r, key_nxt;
  logic [IW-1:0] par_r, par_nxt;
  hnm_tok_t      tok_r, tok_nxt;
  logic [IW-1:0] port_r, port_nxt;
  logic          match;

  always_comb begin
    key_nxt = key_r;
    par_nxt = par_r;
    if (wr_en && (wr_addr == MY_IDX)) begin
      key_nxt = wr_key;
      par_nxt = wr_par;
    end
  end

  // only original entries above the searched parent take part
  assign match = tok_in.valid && !tok_in.hit && (key_r == srch_key) &&
                 (par_r == srch_sp) && (MY_IDX > srch_sp) && (MY_IDX < orig_cnt);

  always_comb begin
    tok_nxt.valid = tok_in.valid;
    tok_nxt.hit   = tok_in.hit | match;
    port_nxt      = tok_in.hit ? port_in : MY_IDX;
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    par_r  <= par_nxt;
    port_r <= port_nxt;
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out  = tok_r;
  assign port_out = port_r;

endmodule

// ----- rtl/core/hierarchy_node_mapper.sv -----
// ----------------------------------------------------------------------------
// hierarchy_node_mapper
// Maps source hierarchy nodes onto a target hierarchy table held in a cell row.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A load item goes from its check
// straight to the output; a map item of the root, or one with a bad parent or
// a full source list, does the same. A map item with a parent first reads the
// parent's mapping from the source mapping memory, a registered read; when
// that parent is unmapped or was appended the result follows without a
// search. Any map item that needs a search then sends a token down the row of
// NODES cells, one cell per cycle; a parentless search starts from the check
// and a search under a mapped parent after the parent read, and the row length
// sets how long the slowest item holds the input. The next item is taken as
// soon as the result sits in the output register, even if it has not yet been
// taken; a result waits only while that register is still full and not being
// taken. Target and source stores come up undefined; no clearing pass is run.
// ----------------------------------------------------------------------------
module hierarchy_node_mapper #(
  parameter int NODES    = hnm_pkg::NODES_DEF,
  parameter int KEY_BITS = hnm_pkg::KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hnm_in_if.sink    in_chan,
  hnm_out_if.source out_chan,
  hnm_cfg_if.sink   cfg_chan
);
  import hnm_pkg::*;

  // index and count width: wide enough for NODES itself and for the 8-bit ports
  localparam int CW = $clog2(NODES + 1);
  localparam int IW = (CW > PORT_W) ? CW : PORT_W;
  localparam int AW = $clog2(NODES);
  // keys are compared in their low KEY_BITS bits of the 32-bit field
  localparam int KW = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;

  localparam logic [IW-1:0] EMPTY   = IW'(EMPTY_PORT);
  localparam logic [IW-1:0] NODES_W = IW'(NODES);

  hnm_state_t state_r, state_nxt;

  // configuration
  logic merge_r, merge_nxt;

  // table counts
  logic [IW-1:0] tcount_r, tcount_nxt;
  logic [IW-1:0] orig_r, orig_nxt;
  logic [IW-1:0] scount_r, scount_nxt;

  // item under work
  logic          op_r, op_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic [IW-1:0] par_r, par_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] mp_r, mp_nxt;
  logic [IW-1:0] sp_r, sp_nxt;

  // pending result and output register
  logic [IW-1:0] res_port_r, res_port_nxt;
  logic          res_app_r, res_app_nxt;
  hnm_status_t   res_stat_r, res_stat_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [PORT_W-1:0] out_port_r, out_port_nxt;
  logic          out_app_r, out_app_nxt;
  hnm_status_t   out_stat_r, out_stat_nxt;

  // source mapping memory
  logic [IW-1:0] map_mem [NODES];
  logic [IW-1:0] map_rd_r;

  // sequencer actions
  logic          in_fire;
  logic          cell_wr;
  logic [IW-1:0] cell_wr_par;
  logic          map_wr;
  logic [AW-1:0] map_wr_addr;
  logic [IW-1:0] map_wr_data;
  logic          map_rd;
  logic          launch;
  logic [IW-1:0] launch_sp;
  logic          tcount_inc, orig_set, scount_inc;
  logic          res_load;
  logic [IW-1:0] res_port;
  logic          res_app;
  hnm_status_t   res_stat;
  logic          miss;
  logic [IW-1:0] mp_cur;
  logic          out_load;

  // token row
  hnm_tok_t      tok_flags [NODES+1];
  logic [IW-1:0] tok_port  [NODES+1];

  assign in_chan.ready  = (state_r == S_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  // parent mapping as seen by the current step
  assign mp_cur = (state_r == S_PARENT) ? map_rd_r : mp_r;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (launch)      state_nxt = S_SEARCH;
        else if (map_rd) state_nxt = S_PARENT;
        else             state_nxt = S_OUT;
      end
      S_PARENT: begin
        state_nxt = launch ? S_SEARCH : S_OUT;
      end
      S_SEARCH: begin
        if (tok_flags[NODES].valid) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer actions
  // --------------------------------------------------------------------------
  always_comb begin
    cell_wr     = 1'b0;
    cell_wr_par = par_r;
    map_wr      = 1'b0;
    map_wr_addr = idx_r[AW-1:0];
    map_wr_data = EMPTY;
    map_rd      = 1'b0;
    launch      = 1'b0;
    launch_sp   = '0;
    tcount_inc  = 1'b0;
    orig_set    = 1'b0;
    scount_inc  = 1'b0;
    res_load    = 1'b0;
    res_port    = EMPTY;
    res_app     = 1'b0;
    res_stat    = STAT_OK;
    miss        = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
      end
      S_CHECK: begin
        res_load = 1'b1;
        if (op_r == OP_LOAD) begin
          if (tcount_r >= NODES_W) begin
            res_stat = STAT_TGT_FULL;
          end else if ((par_r != EMPTY) && (par_r >= tcount_r)) begin
            res_stat = STAT_BAD_PARENT;
          end else begin
            cell_wr    = 1'b1;
            tcount_inc = 1'b1;
            orig_set   = 1'b1;
            res_port   = tcount_r;
          end
        end else begin
          if (scount_r >= NODES_W) begin
            res_stat = STAT_SRC_FULL;
          end else begin
            scount_inc  = 1'b1;
            map_wr_addr = scount_r[AW-1:0];
            if (scount_r == '0) begin
              // root always lands on port 0
              map_wr      = 1'b1;
              map_wr_data = '0;
              res_port    = '0;
            end else if ((par_r != EMPTY) && (par_r >= scount_r)) begin
              map_wr   = 1'b1;
              res_stat = STAT_BAD_PARENT;
            end else if (par_r == EMPTY) begin
              res_load = 1'b0;
              launch   = 1'b1;
            end else begin
              res_load = 1'b0;
              map_rd   = 1'b1;
            end
          end
        end
      end
      S_PARENT: begin
        if (map_rd_r == EMPTY) begin
          // unmapped parent: child stays unmapped
          map_wr   = 1'b1;
          res_load = 1'b1;
        end else if (map_rd_r >= orig_r) begin
          // appended parent: nothing to search
          miss = 1'b1;
        end else begin
          launch    = 1'b1;
          launch_sp = map_rd_r;
        end
      end
      S_SEARCH: begin
        if (tok_flags[NODES].valid) begin
          if (tok_flags[NODES].hit) begin
            map_wr      = 1'b1;
            map_wr_data = tok_port[NODES];
            res_load    = 1'b1;
            res_port    = tok_port[NODES];
          end else begin
            miss = 1'b1;
          end
        end
      end
      S_OUT: begin
        out_load = !out_valid_r || out_chan.ready;
      end
      default: begin
      end
    endcase

    if (miss) begin
      res_load = 1'b1;
      map_wr   = 1'b1;
      if (!merge_r) begin
        res_stat = STAT_OK;
      end else if (tcount_r >= NODES_W) begin
        res_stat = STAT_TGT_FULL;
      end else begin
        // append: parent is the mapped parent, or none
        cell_wr     = 1'b1;
        cell_wr_par = mp_cur;
        tcount_inc  = 1'b1;
        map_wr_data = tcount_r;
        res_port    = tcount_r;
        res_app     = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Register next values
  // --------------------------------------------------------------------------
  always_comb begin
    merge_nxt = merge_r;
    if (cfg_chan.valid && cfg_chan.ready) merge_nxt = cfg_chan.merge_enable;
  end

  always_comb begin
    tcount_nxt = tcount_r;
    orig_nxt   = orig_r;
    scount_nxt = scount_r;
    // a first item restarts its table before it is worked on
    if (in_fire && in_chan.first) begin
      if (in_chan.operation == OP_LOAD) begin
        tcount_nxt = '0;
        orig_nxt   = '0;
      end else begin
        scount_nxt = '0;
        orig_nxt   = tcount_r;
      end
    end
    if (tcount_inc) tcount_nxt = tcount_r + IW'(1);
    if (orig_set)   orig_nxt   = tcount_r + IW'(1);
    if (scount_inc) scount_nxt = scount_r + IW'(1);
  end

  always_comb begin
    op_nxt  = op_r;
    key_nxt = key_r;
    par_nxt = par_r;
    idx_nxt = idx_r;
    mp_nxt  = mp_r;
    sp_nxt  = sp_r;
    if (in_fire) begin
      op_nxt  = in_chan.operation;
      key_nxt = in_chan.node_key[KW-1:0];
      par_nxt = IW'(in_chan.parent_port);
    end
    if (state_r == S_CHECK) begin
      idx_nxt = scount_r;
      mp_nxt  = EMPTY;
    end
    if (state_r == S_PARENT) mp_nxt = map_rd_r;
    if (launch) sp_nxt = launch_sp;
  end

  always_comb begin
    res_port_nxt = res_port_r;
    res_app_nxt  = res_app_r;
    res_stat_nxt = res_stat_r;
    if (res_load) begin
      res_port_nxt = res_port;
      res_app_nxt  = res_app;
      res_stat_nxt = res_stat;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_port_nxt  = out_port_r;
    out_app_nxt   = out_app_r;
    out_stat_nxt  = out_stat_r;
    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_port_nxt  = res_port_r[PORT_W-1:0];
      out_app_nxt   = res_app_r;
      out_stat_nxt  = res_stat_r;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    par_r      <= par_nxt;
    idx_r      <= idx_nxt;
    mp_r       <= mp_nxt;
    sp_r       <= sp_nxt;
    res_port_r <= res_port_nxt;
    res_app_r  <= res_app_nxt;
    res_stat_r <= res_stat_nxt;
    out_port_r <= out_port_nxt;
    out_app_r  <= out_app_nxt;
    out_stat_r <= out_stat_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      merge_r     <= 1'b1;
      tcount_r    <= '0;
      orig_r      <= '0;
      scount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      merge_r     <= merge_nxt;
      tcount_r    <= tcount_nxt;
      orig_r      <= orig_nxt;
      scount_r    <= scount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // source mapping memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (map_wr) map_mem[map_wr_addr] <= map_wr_data;
    if (map_rd) map_rd_r <= map_mem[par_r[AW-1:0]];
  end

  // --------------------------------------------------------------------------
  // Target table: one cell per entry, search token advances a cell per cycle
  // --------------------------------------------------------------------------
  assign tok_flags[0].valid = launch;
  assign tok_flags[0].hit   = 1'b0;
  assign tok_port[0]        = '0;

  for (genvar i = 0; i < NODES; i++) begin : g_cell
    hnm_cell #(
      .IW  (IW),
      .KW  (KW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (cell_wr),
      .wr_addr  (tcount_r),
      .wr_key   (key_r),
      .wr_par   (cell_wr_par),
      .srch_key (key_r),
      .srch_sp  (sp_r),
      .orig_cnt (orig_r),
      .tok_in   (tok_flags[i]),
      .port_in  (tok_port[i]),
      .tok_out  (tok_flags[i+1]),
      .port_out (tok_port[i+1])
    );
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.mapped_port = out_port_r;
  assign out_chan.appended    = out_app_r;
  assign out_chan.status      = out_stat_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_tok_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tok_flags[NODES].valid |-> (state_r == S_SEARCH))
    else $error("search token left the row outside the search state");

  a_orig_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    (orig_r <= tcount_r) && (tcount_r <= NODES_W))
    else $error("target counts out of order");

  a_src_count: assert property (@(posedge clk) disable iff (!rst_n)
    scount_r <= NODES_W)
    else $error("source count beyond depth");

  a_append_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_app_r) |-> (out_stat_r == STAT_OK))
    else $error("appended result with error status");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && res_app) |=> (tcount_r == $past(tcount_r) + IW'(1)))
    else $error("append did not grow the target table");

endmodule
